// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DHKT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define DHKT_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== design/dhkt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhkt_pkg
// Field widths, codes and state types of the double-hashing key table.
// ----------------------------------------------------------------------------
package dhkt_pkg;

  localparam int KEY_W    = 31;
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 9;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int STAT_W   = 2;
  localparam int MIN_SIZE = 3;

  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 9'd251;

  typedef enum logic [STAT_W-1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_LIVE    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_stat_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_FULL      = 3'd1,
    RES_HIT       = 3'd2,
    RES_MISS      = 3'd3,
    RES_REMOVED   = 3'd4,
    RES_NOT_FOUND = 3'd5
  } res_t;

  typedef enum logic [2:0] {
    FSM_CLEAR = 3'd0,
    FSM_IDLE  = 3'd1,
    FSM_DIV   = 3'd2,
    FSM_READ  = 3'd3,
    FSM_PROBE = 3'd4
  } fsm_t;

endpackage

// ===== design/dhkt_mod_unit.sv =====
// ----------------------------------------------------------------------------
// dhkt_mod_unit
// Bit-serial restoring remainder: key mod divisor, one key bit per cycle.
// ----------------------------------------------------------------------------
module dhkt_mod_unit #(
  parameter int DIV_W = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dhkt_pkg::KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          remainder
);
  import dhkt_pkg::*;

  localparam int CNT_W = $clog2(KEY_W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] shift_r, shift_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // divisor is held stable by the caller for the whole run
  assign trial = {rem_r, shift_r[KEY_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = dividend;
      rem_nxt   = '0;
    end else if (run_r) begin
      rem_nxt   = (trial >= {1'b0, divisor}) ? DIV_W'(diff) : DIV_W'(trial);
      shift_nxt = {shift_r[KEY_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== design/dhkt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// dhkt_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dhkt_slot_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 33
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/double_hash_key_table_core.sv =====
// Sequence: key taken, both remainders computed bit-serially, first slot read, then P probes,
//   P = probes taken (1 .. table size); result strobe comes the cycle after the last probe.
// Transactions: one at a time, a new start is taken only while idle;
//   the probe loop is bounded by the single slot store read port, one probe a cycle.
// Reset: synchronous, active low; afterwards busy stays high while every slot is cleared
//   to empty. The result side cannot stall.
// ----------------------------------------------------------------------------
// double_hash_key_table_core
// Open-addressing key set with double hashing, status and keys in one RAM.
// ----------------------------------------------------------------------------
module double_hash_key_table_core #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dhkt_pkg::MODE_W-1:0]  in_mode,
  input  logic [dhkt_pkg::KEY_W-1:0]   in_key,
  input  logic                         cfg_we,
  input  logic [dhkt_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [dhkt_pkg::STATUS_W-1:0] out_status,
  output logic [dhkt_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [dhkt_pkg::COUNT_W-1:0] out_key_count
);
  import dhkt_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam int DW = STAT_W + KEY_W;

  fsm_t              state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_size_r;
  logic [IW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     step_r, step_nxt;
  logic [SW-1:0]     probe_cnt_r, probe_cnt_nxt;
  logic [SW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic [CW-1:0]     ts_ext;
  logic [SW-1:0]     eff_size;
  logic [SW-1:0]     r_val;
  logic              div_start;
  logic              done_s, done_r;
  logic [SW-1:0]     rem_s, rem_r;
  logic [SW:0]       pos_sum;
  logic [IW-1:0]     pos_adv;
  logic              last_probe;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;
  slot_stat_t        rd_stat;
  logic [KEY_W-1:0]  rd_key;

  // effective size: clamp the register to [MIN_SIZE, MAX_SLOTS]
  assign ts_ext = CW'(cfg_size_r);
  always_comb begin
    if (ts_ext < CW'(MIN_SIZE)) begin
      eff_size = SW'(MIN_SIZE);
    end else if (ts_ext > CW'(MAX_SLOTS)) begin
      eff_size = SW'(MAX_SLOTS);
    end else begin
      eff_size = SW'(ts_ext);
    end
  end

  assign r_val = size_r - SW'(2);

  dhkt_mod_unit #(.DIV_W(SW)) u_mod_size (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_key),
    .divisor   (size_r),
    .done      (done_s),
    .remainder (rem_s)
  );

  dhkt_mod_unit #(.DIV_W(SW)) u_mod_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_key),
    .divisor   (r_val),
    .done      (done_r),
    .remainder (rem_r)
  );

  dhkt_slot_ram #(.DEPTH(MAX_SLOTS), .ADDR_W(IW), .DATA_W(DW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_stat = slot_stat_t'(ram_rdata[DW-1:KEY_W]);
  assign rd_key  = ram_rdata[KEY_W-1:0];

  // pos < size and step < size, so one conditional subtract wraps the sum
  assign pos_sum    = {1'b0, SW'(pos_r)} + {1'b0, SW'(step_r)};
  assign pos_adv    = (pos_sum >= {1'b0, size_r}) ? IW'(pos_sum - {1'b0, size_r})
                                                  : IW'(pos_sum);
  assign last_probe = (probe_cnt_r == size_r - SW'(1));

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    key_nxt        = key_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    probe_cnt_nxt  = probe_cnt_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {SLOT_LIVE, key_r};
    ram_raddr      = pos_r;

    unique case (state_r)
      FSM_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = {SLOT_EMPTY, {KEY_W{1'b0}}};
        clr_addr_nxt = clr_addr_r + IW'(1);
        if (clr_addr_r == IW'(MAX_SLOTS - 1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (start) begin
          key_nxt   = in_key;
          mode_nxt  = in_mode;
          size_nxt  = eff_size;
          div_start = 1'b1;
          state_nxt = FSM_DIV;
        end
      end
      FSM_DIV: begin
        if (done_s && done_r) begin
          pos_nxt       = IW'(rem_s);
          step_nxt      = IW'(r_val - rem_r);
          probe_cnt_nxt = '0;
          state_nxt     = FSM_READ;
        end
      end
      FSM_READ: begin
        state_nxt = FSM_PROBE;
      end
      FSM_PROBE: begin
        // one probe a cycle; the store is only written when the transaction ends,
        // so no read of this transaction can see a write in flight
        if (mode_r == MODE_INSERT) begin
          if (rd_stat != SLOT_LIVE) begin
            ram_we         = 1'b1;
            ram_wdata      = {SLOT_LIVE, key_r};
            if (count_r < SW'(MAX_SLOTS)) begin
              count_nxt = count_r + SW'(1);
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_INSERTED;
            out_slot_nxt   = SLOT_W'(pos_r);
            state_nxt      = FSM_IDLE;
          end else if (last_probe) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_FULL;
            out_slot_nxt   = '0;
            state_nxt      = FSM_IDLE;
          end else begin
            pos_nxt       = pos_adv;
            ram_raddr     = pos_adv;
            probe_cnt_nxt = probe_cnt_r + SW'(1);
          end
        end else begin
          if (rd_stat == SLOT_LIVE && rd_key == key_r) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = SLOT_W'(pos_r);
            state_nxt     = FSM_IDLE;
            if (mode_r == MODE_REMOVE) begin
              ram_we         = 1'b1;
              ram_wdata      = {SLOT_DELETED, rd_key};
              if (count_r != '0) begin
                count_nxt = count_r - SW'(1);
              end
              out_status_nxt = RES_REMOVED;
            end else begin
              out_status_nxt = RES_HIT;
            end
          end else if (rd_stat == SLOT_EMPTY || last_probe) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = (mode_r == MODE_REMOVE) ? RES_NOT_FOUND : RES_MISS;
            out_slot_nxt   = '0;
            state_nxt      = FSM_IDLE;
          end else begin
            pos_nxt       = pos_adv;
            ram_raddr     = pos_adv;
            probe_cnt_nxt = probe_cnt_r + SW'(1);
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_size_r  <= CFG_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign busy           = (state_r != FSM_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_key_count  = COUNT_W'(count_r);

endmodule

// ===== design/dhkt_checker.sv =====
// ----------------------------------------------------------------------------
// dhkt_assert_checker
// Port-level checks on the key table core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhkt_assert_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [dhkt_pkg::STATUS_W-1:0] out_status,
  input logic [dhkt_pkg::SLOT_W-1:0]   out_slot_index,
  input logic [dhkt_pkg::COUNT_W-1:0]  out_key_count
);
  import dhkt_pkg::*;

  `DHKT_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy,
               "no busy after accept")
  `DHKT_ASSERT(a_result_ends_busy, clk, rst_n, out_valid |-> (!busy && $past(busy)),
               "result strobe outside end of transaction")
  `DHKT_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status <= RES_NOT_FOUND),
               "bad status code")
  `DHKT_ASSERT(a_miss_slot_zero, clk, rst_n,
               (out_valid && (out_status == RES_FULL || out_status == RES_MISS ||
                              out_status == RES_NOT_FOUND)) |-> (out_slot_index == '0),
               "slot index not zero on miss")
  `DHKT_ASSERT(a_count_stable, clk, rst_n,
               (!out_valid && !$past(out_valid) && !busy) |-> $stable(out_key_count),
               "key count moved while idle")

endmodule

bind double_hash_key_table_core dhkt_assert_checker u_dhkt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_slot_index (out_slot_index),
  .out_key_count  (out_key_count)
);
